FILE: rtl/llh_pkg.sv
package llh_pkg;

	// Command codes.
	localparam logic [1:0] CMD_RECORD = 2'd0;
	localparam logic [1:0] CMD_PCTL   = 2'd1;
	localparam logic [1:0] CMD_STATS  = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_MAX_LAT   = 2'd0;
	localparam logic [1:0] REG_LOG2_MAX  = 2'd1;
	localparam logic [1:0] REG_BKT_SCALE = 2'd2;

	// Fixed field widths.
	localparam int LAT_BITS = 48;

	// Parameter defaults.
	localparam int DEF_BUCKETS    = 32;
	localparam int DEF_COUNT_BITS = 32;

	// Register reset values.
	localparam logic [47:0] RST_MAX_LAT   = 48'd1000000000;
	localparam logic [15:0] RST_LOG2_MAX  = 16'd30614;
	localparam logic [23:0] RST_BKT_SCALE = 24'd1122302;

	// Q1.20 mantissa bounds.
	localparam logic [20:0] MANT_ONE = 21'h100000;
	localparam logic [20:0] MANT_MAX = 21'h1FFFFF;

endpackage

FILE: rtl/llh_ram.sv
module llh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/log_latency_histogram_unit.sv
// A record finds the fraction log2 by repeated squaring, scales it to a bucket index,
// increments that bucket, then recomputes the average by bit-serial division. A percentile
// query scans the buckets, binary-searches the bound on the shared squaring multiplier and
// divides. Statistics and clear run only the division; one request is in work at a time.
// Reset (arst_n low) clears the statistics and valid bits and reloads the config registers.
module log_latency_histogram_unit
	import llh_pkg::*;
#(
	parameter int BUCKETS    = DEF_BUCKETS,
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [47:0] lat_sample,
	input  logic [16:0] percentile_q16,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [47:0] percentile_ns,
	output logic [7:0]  percentile_bucket,
	output logic [31:0] sample_count,
	output logic [47:0] min_ns,
	output logic [47:0] max_ns,
	output logic [47:0] avg_ns,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam logic [BW-1:0] LAST = BW'(BUCKETS - 1);
	localparam int CW = COUNT_BITS + BW + 1;

	// Reciprocal of the bucket count, exact for every bound product.
	localparam int XN = BW + 17;
	localparam int XS = XN + BW;
	localparam logic [XN:0] X_RECIP =
		(XN+1)'(((64'd1 << XS) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_LOGSQ = 5'd1;
	localparam logic [4:0] S_IDX   = 5'd2;
	localparam logic [4:0] S_IDXC  = 5'd3;
	localparam logic [4:0] S_RD    = 5'd4;
	localparam logic [4:0] S_WR    = 5'd5;
	localparam logic [4:0] S_PTGT  = 5'd6;
	localparam logic [4:0] S_SRD   = 5'd7;
	localparam logic [4:0] S_SACC  = 5'd8;
	localparam logic [4:0] S_XMUL  = 5'd9;
	localparam logic [4:0] S_XDIV  = 5'd10;
	localparam logic [4:0] S_BSMID = 5'd11;
	localparam logic [4:0] S_BSSQ  = 5'd12;
	localparam logic [4:0] S_EXP   = 5'd13;
	localparam logic [4:0] S_AVG   = 5'd14;
	localparam logic [4:0] S_DIV   = 5'd15;
	localparam logic [4:0] S_OUT   = 5'd16;

	logic [4:0] state_q;

	// Configuration registers.
	logic [47:0] max_lat_q;
	logic [15:0] log2_max_q;
	logic [23:0] scale_q;

	// Request and statistics registers.
	logic [16:0]           pq_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [63:0]           sum_q;
	logic [47:0]           min_q;
	logic [47:0]           max_q;
	logic [BUCKETS-1:0]    valid_q;

	// Working registers.
	logic [5:0]            p_q;
	logic [20:0]           sq_m_q;
	logic [9:0]            sq_r_q;
	logic [3:0]            sq_k_q;
	logic [39:0]           idxprod_q;
	logic [BW-1:0]         addr_q;
	logic [COUNT_BITS:0]   tgt_q;
	logic [CW-1:0]         cum_q;
	logic [BW+16:0]        xprod_q;
	logic [5:0]            e_q;
	logic [9:0]            f_q;
	logic [20:0]           lo_q;
	logic [20:0]           hi_q;
	logic [20:0]           mid_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [63:0]           quo_q;
	logic [5:0]            div_k_q;

	// Result registers.
	logic        status_q;
	logic [47:0] pns_q;
	logic [BW-1:0] pbk_q;
	logic [47:0] avg_q;
	logic        out_valid_q;

	// Bucket memory.
	logic                  ram_we;
	logic [COUNT_BITS-1:0] ram_wdata;
	logic                  ram_re;
	logic [BW-1:0]         ram_raddr;
	logic [COUNT_BITS-1:0] ram_rdata;

	llh_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(BUCKETS),
		.AW(BW)
	) u_bucket_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(addr_q),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Leading one position of a sample.
	function automatic logic [5:0] lead_one(input logic [47:0] v);
		logic [5:0] r;
		r = 6'd0;
		for (int i = 0; i < 48; i++) begin
			if (v[i]) begin
				r = 6'(i);
			end
		end
		return r;
	endfunction

	// Input side decode.
	logic [5:0]  in_p;
	logic [47:0] in_norm;
	logic [64:0] in_sum;
	assign in_p    = lead_one(lat_sample);
	assign in_norm = lat_sample << (6'd47 - in_p);
	assign in_sum  = {1'b0, sum_q} + {17'd0, lat_sample};

	// One squaring step of the fraction log2.
	logic [41:0] sq_prod;
	logic [21:0] sq_sh;
	logic [20:0] sq_m_n;
	logic [9:0]  sq_r_n;
	assign sq_prod = sq_m_q * sq_m_q;
	assign sq_sh   = sq_prod[41:20];
	assign sq_m_n  = sq_sh[21] ? sq_sh[21:1] : sq_sh[20:0];
	assign sq_r_n  = {sq_r_q[8:0], sq_sh[21]};

	// Bucket read data, zero where never written since clear.
	logic [COUNT_BITS-1:0] bkt_cur;
	logic [CW-1:0]         cum_n;
	assign bkt_cur = valid_q[addr_q] ? ram_rdata : '0;
	assign cum_n   = cum_q + CW'(bkt_cur);

	// Products that feed registers; the bucket count division is a reciprocal multiply.
	logic [39:0]            idx_prod;
	logic [COUNT_BITS+16:0] tgt_prod;
	logic [BW+16:0]         x_prod;
	logic [9:0]             idx_raw;
	logic [2*XN:0]          x_full;
	logic [15:0]            x_div;
	assign idx_prod = {p_q, sq_r_q} * scale_q;
	assign tgt_prod = pq_q * cnt_q;
	assign x_prod   = ({1'b0, pbk_q} + (BW+1)'(1)) * log2_max_q;
	assign idx_raw  = idxprod_q[39:30];
	assign x_full   = xprod_q * X_RECIP;
	assign x_div    = x_full[XS+15:XS];

	// Binary search midpoint and bound shift.
	logic [21:0] bs_sum;
	logic [63:0] exp_val;
	assign bs_sum  = {1'b0, lo_q} + {1'b0, hi_q} + 22'd1;
	assign exp_val = (e_q >= 6'd20) ? (64'(lo_q) << (e_q - 6'd20))
	                                : (64'(lo_q) >> (6'd20 - e_q));

	// Divider step.
	logic [COUNT_BITS:0] rem_n;
	logic                rem_ge;
	assign rem_n  = {rem_q, quo_q[63]};
	assign rem_ge = rem_n >= {1'b0, cnt_q};

	// Memory control.
	always_comb begin
		ram_re    = (state_q == S_RD) || (state_q == S_SRD);
		ram_raddr = addr_q;
		ram_we    = (state_q == S_WR);
		ram_wdata = (&bkt_cur) ? bkt_cur : bkt_cur + COUNT_BITS'(1);
	end

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_lat_q  <= RST_MAX_LAT;
			log2_max_q <= RST_LOG2_MAX;
			scale_q    <= RST_BKT_SCALE;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MAX_LAT:   max_lat_q  <= cfg_data;
				REG_LOG2_MAX:  log2_max_q <= cfg_data[15:0];
				REG_BKT_SCALE: scale_q    <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// Main sequencer and statistics.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			sum_q       <= '0;
			min_q       <= '1;
			max_q       <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						pq_q     <= percentile_q16;
						status_q <= 1'b0;
						pns_q    <= '0;
						pbk_q    <= '0;
						case (cmd)
							CMD_RECORD: begin
								if (!(&cnt_q)) begin
									cnt_q <= cnt_q + COUNT_BITS'(1);
								end
								sum_q <= in_sum[64] ? '1 : in_sum[63:0];
								if (lat_sample < min_q) begin
									min_q <= lat_sample;
								end
								if (lat_sample > max_q) begin
									max_q <= lat_sample;
								end
								p_q    <= in_p;
								sq_m_q <= in_norm[47:27];
								sq_r_q <= '0;
								sq_k_q <= '0;
								addr_q <= '0;
								state_q <= (lat_sample == '0) ? S_RD : S_LOGSQ;
							end
							CMD_PCTL: begin
								if (percentile_q16 > 17'd65536 || cnt_q == '0) begin
									status_q <= 1'b1;
									state_q  <= S_AVG;
								end else begin
									state_q <= S_PTGT;
								end
							end
							CMD_CLEAR: begin
								cnt_q   <= '0;
								sum_q   <= '0;
								min_q   <= '1;
								max_q   <= '0;
								valid_q <= '0;
								state_q <= S_AVG;
							end
							default: state_q <= S_AVG;
						endcase
					end
				end
				S_LOGSQ: begin
					sq_m_q <= sq_m_n;
					sq_r_q <= sq_r_n;
					sq_k_q <= sq_k_q + 4'd1;
					if (sq_k_q == 4'd9) begin
						state_q <= S_IDX;
					end
				end
				S_IDX: begin
					idxprod_q <= idx_prod;
					state_q   <= S_IDXC;
				end
				S_IDXC: begin
					addr_q  <= (idx_raw > 10'(BUCKETS - 1)) ? LAST : BW'(idx_raw);
					state_q <= S_RD;
				end
				S_RD: state_q <= S_WR;
				S_WR: begin
					valid_q[addr_q] <= 1'b1;
					state_q         <= S_AVG;
				end
				S_PTGT: begin
					tgt_q   <= tgt_prod[COUNT_BITS+16:16];
					cum_q   <= '0;
					addr_q  <= '0;
					state_q <= S_SRD;
				end
				S_SRD: state_q <= S_SACC;
				S_SACC: begin
					cum_q <= cum_n;
					if (cum_n >= CW'(tgt_q)) begin
						pbk_q   <= addr_q;
						state_q <= S_XMUL;
					end else if (addr_q == LAST) begin
						pbk_q   <= LAST;
						pns_q   <= max_lat_q;
						state_q <= S_AVG;
					end else begin
						addr_q  <= addr_q + BW'(1);
						state_q <= S_SRD;
					end
				end
				S_XMUL: begin
					xprod_q <= x_prod;
					state_q <= S_XDIV;
				end
				S_XDIV: begin
					e_q     <= x_div[15:10];
					f_q     <= x_div[9:0];
					lo_q    <= MANT_ONE;
					hi_q    <= MANT_MAX;
					state_q <= S_BSMID;
				end
				S_BSMID: begin
					if (lo_q < hi_q) begin
						mid_q   <= bs_sum[21:1];
						sq_m_q  <= bs_sum[21:1];
						sq_r_q  <= '0;
						sq_k_q  <= '0;
						state_q <= S_BSSQ;
					end else begin
						state_q <= S_EXP;
					end
				end
				S_BSSQ: begin
					sq_m_q <= sq_m_n;
					sq_r_q <= sq_r_n;
					sq_k_q <= sq_k_q + 4'd1;
					if (sq_k_q == 4'd9) begin
						if (sq_r_n <= f_q) begin
							lo_q <= mid_q;
						end else begin
							hi_q <= mid_q - 21'd1;
						end
						state_q <= S_BSMID;
					end
				end
				S_EXP: begin
					if (e_q >= 6'(LAT_BITS) || exp_val[63:48] != '0) begin
						pns_q <= '1;
					end else begin
						pns_q <= exp_val[47:0];
					end
					state_q <= S_AVG;
				end
				S_AVG: begin
					rem_q   <= '0;
					quo_q   <= sum_q;
					div_k_q <= '0;
					if (cnt_q == '0) begin
						avg_q   <= '0;
						state_q <= S_OUT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q   <= rem_ge ? COUNT_BITS'(rem_n - {1'b0, cnt_q}) : rem_n[COUNT_BITS-1:0];
					quo_q   <= {quo_q[62:0], rem_ge};
					div_k_q <= div_k_q + 6'd1;
					if (div_k_q == 6'd63) begin
						state_q <= S_OUT;
						if (quo_q[62:47] != '0) begin
							avg_q <= '1;
						end else begin
							avg_q <= {quo_q[46:0], rem_ge};
						end
					end
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register loaded when the request completes.
	logic [63:0] cnt_wide;
	assign cnt_wide = 64'(cnt_q);

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!out_valid_q || !out_stall)) begin
			status            <= status_q;
			percentile_ns     <= pns_q;
			percentile_bucket <= 8'(pbk_q);
			sample_count      <= (cnt_wide > 64'hFFFF_FFFF) ? '1 : cnt_wide[31:0];
			min_ns            <= min_q;
			max_ns            <= max_q;
			avg_ns            <= avg_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/llh_checker.sv
module llh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        status,
	input logic [47:0] percentile_ns,
	input logic [7:0]  percentile_bucket,
	input logic [31:0] sample_count,
	input logic [47:0] max_ns,
	input logic [47:0] avg_ns
);

	// A taken request keeps the block busy for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted twice in a row");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(avg_ns) && $stable(sample_count))
		else $error("stalled result changed");

	// An error result carries no percentile.
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> percentile_ns == '0 && percentile_bucket == '0)
		else $error("error result with percentile data");

	// An empty histogram reports zero maximum and average.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sample_count == '0 |-> avg_ns == '0 && max_ns == '0)
		else $error("empty histogram with nonzero statistics");

endmodule

bind log_latency_histogram_unit llh_checker u_llh_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.status(status),
	.percentile_ns(percentile_ns),
	.percentile_bucket(percentile_bucket),
	.sample_count(sample_count),
	.max_ns(max_ns),
	.avg_ns(avg_ns)
);
